/* rtl/core/jbdm_pkg.sv */
package jbdm_pkg;

    // Item kinds carried in the input tuser bit.
    typedef enum logic {
        OP_TICK = 1'b0,
        OP_BYTE = 1'b1
    } t_op;

    // Bit 0 of a command byte selects which group of fields it updates.
    localparam logic TGT_SPEED = 1'b0;
    localparam logic TGT_TURN  = 1'b1;

    // Command byte layout.
    localparam int unsigned BIT_TARGET = 0;
    localparam int unsigned BIT_BOOST  = 1;
    localparam int unsigned BIT_MAG_LO = 3;
    localparam int unsigned BIT_SENSE  = 6;

    localparam int unsigned MAG_W  = 3;
    localparam int unsigned DUTY_W = 7;
    localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

    // Result beat layout, lowest bit first.
    localparam int unsigned OUT_DATA_W = 24;

    typedef struct packed {
        logic [MAG_W-1:0] speed;
        logic             reverse;
        logic             boost;
        logic [MAG_W-1:0] turn;
        logic             turn_sense;
    } t_drive;

    typedef struct packed {
        logic [DUTY_W-1:0] left;
        logic [DUTY_W-1:0] right;
        logic              ldir;
        logic              rdir;
    } t_mix;

    // floor(x / 7) for x up to 1190, by reciprocal multiplication (2341 / 2^14).
    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [21:0] p;
        p = 22'(x) * 22'd2341;
        return p[21:14];
    endfunction

    function automatic logic [DUTY_W-1:0] clamp_duty(input logic [7:0] v);
        return (v > 8'(DUTY_MAX)) ? DUTY_MAX : v[DUTY_W-1:0];
    endfunction

    // Duty mixing. With s = speed and t = turn, s*100*t/10 is exactly 10*s*t,
    // so the two sides are 10*s*(10+t)/7 and 10*s*(10-t)/7.
    function automatic t_mix mix(input t_drive d);
        t_mix        r;
        logic [6:0]  prod_hi;
        logic [6:0]  prod_lo;
        logic [10:0] sum_hi;
        logic [10:0] sum_lo;
        logic [DUTY_W-1:0] hi;
        logic [DUTY_W-1:0] lo;
        logic [DUTY_W-1:0] l;
        logic [DUTY_W-1:0] rr;
        prod_hi = 7'(d.speed) * (7'd10 + 7'(d.turn));
        prod_lo = 7'(d.speed) * (7'd10 - 7'(d.turn));
        sum_hi  = 11'(prod_hi) * 11'd10;
        sum_lo  = 11'(prod_lo) * 11'd10;
        hi = clamp_duty(div7(sum_hi));
        lo = clamp_duty(div7(sum_lo));
        if (d.speed == '0) begin
            l      = 7'(d.turn) * 7'd7;
            rr     = l;
            r.ldir = d.turn_sense;
            r.rdir = ~d.turn_sense;
        end else begin
            l      = d.turn_sense ? hi : lo;
            rr     = d.turn_sense ? lo : hi;
            r.ldir = d.reverse;
            r.rdir = d.reverse;
        end
        if (!d.boost) begin
            l  = l >> 1;
            rr = rr >> 1;
        end
        r.left  = l;
        r.right = rr;
        return r;
    endfunction

endpackage

/* rtl/core/joystick_byte_to_dual_motor_pwm_unit.sv */
// Channel   Direction  Beat content
// s_axis    in         tdata = rx_byte[7:0]; tuser = operation (0 tick, 1 byte)
// m_axis    out        tdata = pins, byte_accepted, left_duty, right_duty
//
// Every beat moves from the input register through the decode and duty mixing
// logic into the result register.
// A new beat is accepted every cycle while the result side keeps taking beats.
// A stall on m_axis fills the result and then the input register before s_axis_tready falls.
// Reset (i_rst_n low, synchronous) clears the phase, the command fields and the pins,
// and empties both registers.
module joystick_byte_to_dual_motor_pwm_unit #(
    parameter int unsigned PWM_PERIOD = 100
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] rx_byte
    input  logic [7:0]  s_axis_tdata,
    // [0] operation
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] m1_fwd, [1] m1_bwd, [2] m2_fwd, [3] m2_bwd, [4] byte_accepted,
    // [11:5] left_duty, [18:12] right_duty, [23:19] zero
    output logic [jbdm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import jbdm_pkg::*;

    // The phase only ever holds 0 .. PWM_PERIOD-1.
    localparam int unsigned PHASE_W = $clog2(PWM_PERIOD);

    // Input register.
    logic       r_in_valid;
    t_op        r_in_op;
    logic [7:0] r_in_byte;

    // Control state.
    logic [PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0] n_phase;
    t_drive             r_drive;
    t_drive             n_drive;
    logic [3:0]         r_pins;
    logic [3:0]         n_pins;

    // Result register.
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic       advance;
    logic       parity_ok;
    logic       accepted;
    logic [PHASE_W:0] phase_inc;
    t_mix       duty;
    logic       left_on;
    logic       right_on;

    // The mixing stage moves a held input beat when the result register is empty or being drained.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Odd number of ones means the byte arrived intact.
    assign parity_ok = ^r_in_byte;
    assign accepted  = (r_in_op == OP_BYTE) && parity_ok;

    always_comb begin
        n_drive = r_drive;
        if (accepted) begin
            if (r_in_byte[BIT_TARGET] == TGT_SPEED) begin
                n_drive.boost   = r_in_byte[BIT_BOOST];
                n_drive.speed   = r_in_byte[BIT_MAG_LO +: MAG_W];
                n_drive.reverse = r_in_byte[BIT_SENSE];
            end else begin
                n_drive.turn       = r_in_byte[BIT_MAG_LO +: MAG_W];
                n_drive.turn_sense = r_in_byte[BIT_SENSE];
            end
        end
    end

    // The phase advances only on a tick and wraps at the period.
    assign phase_inc = {1'b0, r_phase} + 1'b1;
    always_comb begin
        n_phase = r_phase;
        if (r_in_op == OP_TICK) begin
            n_phase = (phase_inc >= (PHASE_W+1)'(PWM_PERIOD)) ? '0 : phase_inc[PHASE_W-1:0];
        end
    end

    // Duties come from the fields as they stand after this beat's update.
    assign duty     = mix(n_drive);
    assign left_on  = 8'(n_phase) < 8'(duty.left);
    assign right_on = 8'(n_phase) < 8'(duty.right);

    // Each bridge drives either its forward pin (direction 0) or its backward
    // pin (direction 1). Byte beats leave the pins as they were.
    always_comb begin
        n_pins = r_pins;
        if (r_in_op == OP_TICK) begin
            n_pins[0] = left_on  && !duty.ldir;
            n_pins[1] = left_on  &&  duty.ldir;
            n_pins[2] = right_on && !duty.rdir;
            n_pins[3] = right_on &&  duty.rdir;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= '0;
            r_drive     <= '0;
            r_pins      <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
                r_drive     <= n_drive;
                r_pins      <= n_pins;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op   <= t_op'(s_axis_tuser[0]);
            r_in_byte <= s_axis_tdata;
        end
        if (advance) begin
            r_out_data <= {5'b0, duty.right, duty.left, accepted, n_pins};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // A bridge never has both of its pins high at once.
    a_no_shoot_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pins[0] && r_pins[1]) && !(r_pins[2] && r_pins[3]))
        else $error("both pins of one bridge driven");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_phase) < PWM_PERIOD)
        else $error("pwm phase out of range");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data[11:5] <= DUTY_MAX) && (r_out_data[18:12] <= DUTY_MAX))
        else $error("duty above maximum");

    a_byte_holds_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_op == OP_BYTE) |=> (r_pins == $past(r_pins)) &&
                                            (r_phase == $past(r_phase)))
        else $error("byte beat changed pins or phase");

    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_drive) && $stable(r_phase))
        else $error("state changed without a beat moving");

endmodule
